[rtl/servo_overtravel_protect_core_defines.svh]
// Assertion macros used by the servo overtravel protection core.
`ifndef SERVO_OVERTRAVEL_PROTECT_CORE_DEFINES_SVH
`define SERVO_OVERTRAVEL_PROTECT_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk and held off during reset.
`define SOP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and held off during reset.
`define SOP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sop_pkg.sv]
// Package with the types and constants of the servo overtravel protection block.
package sop_pkg;

  // Two-bit direction code.
  typedef logic [1:0] dir_t;

  localparam dir_t DIR_NONE = 2'd0;
  localparam dir_t DIR_POS  = 2'd1;
  localparam dir_t DIR_NEG  = 2'd2;
  localparam dir_t DIR_BOTH = 2'd3;

  // Command sources.
  localparam logic [1:0] SRC_REMOTE = 2'd1;
  localparam logic [1:0] SRC_CMBUS  = 2'd2;

  // Mode groups that matter for the commanded direction.
  localparam logic [2:0] MODE_REMOTE_POS   = 3'd1;
  localparam logic [2:0] MODE_CMBUS_SPD    = 3'd1;
  localparam logic [2:0] MODE_CMBUS_SYNC   = 3'd2;
  localparam logic [2:0] MODE_CMBUS_TORQUE = 3'd3;

  // Configuration register map.
  localparam int CFG_ADDR_WIDTH = 4;
  localparam int CFG_DATA_WIDTH = 32;
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SOFT_SEL  = 2'd0;
  localparam reg_idx_t REG_THRESHOLD = 2'd1;
  localparam reg_idx_t REG_DELAY     = 2'd2;

  // Register widths and reset values.
  localparam int THRESH_WIDTH = 15;
  localparam int DELAY_WIDTH  = 11;
  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 15'd24;
  localparam logic [DELAY_WIDTH-1:0]  DELAY_RESET  = 11'd1000;
  localparam logic [DELAY_WIDTH:0]    COUNT_MAX    = 12'd2047;

endpackage

[rtl/sop_in_if.sv]
// Input channel interface of the servo overtravel protection block.
interface sop_in_if #(
  parameter int POS_WIDTH   = 32,
  parameter int SPEED_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic                          brake_released;
  logic                          speed_nonzero;
  logic [1:0]                    soft_limits;
  logic [1:0]                    hard_limits;
  logic                          regulating;
  logic [1:0]                    homing_masks;
  logic [1:0]                    command_source;
  logic [2:0]                    mode_group;
  logic signed [POS_WIDTH-1:0]   command_value;
  logic signed [POS_WIDTH-1:0]   actual_position;
  logic signed [SPEED_WIDTH-1:0] speed_feedback;

  modport source (
    output valid, brake_released, speed_nonzero, soft_limits, hard_limits, regulating,
           homing_masks, command_source, mode_group, command_value, actual_position,
           speed_feedback,
    input  ready
  );

  modport sink (
    input  valid, brake_released, speed_nonzero, soft_limits, hard_limits, regulating,
           homing_masks, command_source, mode_group, command_value, actual_position,
           speed_feedback,
    output ready
  );
endinterface

[rtl/sop_out_if.sv]
// Result channel interface of the servo overtravel protection block.
interface sop_out_if #(
  parameter int SPEED_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    overtravel_dir;
  logic [1:0]                    ref_dir;
  logic                          stopping;
  logic                          position_locked;
  logic                          load_stop_speed;
  logic signed [SPEED_WIDTH-1:0] stop_speed;
  logic                          raise_pos_warn;
  logic                          raise_neg_warn;
  logic                          clear_warns;
  logic [1:0]                    latched_dir;

  modport source (
    output valid, overtravel_dir, ref_dir, stopping, position_locked, load_stop_speed,
           stop_speed, raise_pos_warn, raise_neg_warn, clear_warns, latched_dir,
    input  ready
  );

  modport sink (
    input  valid, overtravel_dir, ref_dir, stopping, position_locked, load_stop_speed,
           stop_speed, raise_pos_warn, raise_neg_warn, clear_warns, latched_dir,
    output ready
  );
endinterface

[rtl/servo_overtravel_protect_core.sv]
// Servo overtravel protection core: limit tracking, stop and lock control, warnings.
//
// Each request is one control tick. It is registered in the input register on
// acceptance, evaluated against the protection state and written to the result
// register; one request is taken every cycle while results are taken. The only
// loop is the update of the protection state. Soft or hard limits are folded into
// a sticky overtravel direction, a run into the limit starts a zero-speed stop that
// becomes a position lock at or below the speed threshold, and warnings clear on
// release or after the drive has been disabled for more than the release delay.
// Configuration is taken on an APB-style port (registers at byte addresses 0, 4
// and 8); the user is to write it only while idle; the block does not enforce it.
`include "servo_overtravel_protect_core_defines.svh"

module servo_overtravel_protect_core
  import sop_pkg::*;
#(
  parameter int POS_WIDTH   = 32,
  parameter int SPEED_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  sop_in_if.sink                    in_bus,
  sop_out_if.source                 out_bus,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  output logic [CFG_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  // Width of the speed magnitude compare.
  localparam int MAG_WIDTH = ((SPEED_WIDTH > THRESH_WIDTH) ? SPEED_WIDTH : THRESH_WIDTH) + 1;

  // Configuration registers.
  logic                    soft_sel_r;
  logic [THRESH_WIDTH-1:0] thresh_r;
  logic [DELAY_WIDTH-1:0]  delay_r;

  // Input register.
  logic                          s1_valid_r;
  logic                          s1_brake_r;
  logic                          s1_nonzero_r;
  logic [1:0]                    s1_soft_r;
  logic [1:0]                    s1_hard_r;
  logic                          s1_reg_r;
  logic [1:0]                    s1_masks_r;
  logic [1:0]                    s1_src_r;
  logic [2:0]                    s1_mode_r;
  logic signed [POS_WIDTH-1:0]   s1_cmd_r;
  logic signed [POS_WIDTH-1:0]   s1_act_r;
  logic signed [SPEED_WIDTH-1:0] s1_spd_r;

  // Protection state.
  dir_t                 dir_r,     dir_nxt;
  logic                 stop_r,    stop_nxt;
  logic                 lock_r,    lock_nxt;
  dir_t                 refd_r,    refd_nxt;
  dir_t                 latch_r,   latch_nxt;
  logic                 warn_r,    warn_nxt;
  logic [DELAY_WIDTH-1:0] count_r, count_nxt;

  // Result register.
  logic                          out_valid_r;
  logic                          load_r,  load_nxt;
  logic signed [SPEED_WIDTH-1:0] seed_r,  seed_nxt;
  logic                          rpos_r,  rpos_nxt;
  logic                          rneg_r,  rneg_nxt;
  logic                          clr_r,   clr_nxt;

  logic adv;
  logic cfg_wr;

  // Handshake: the evaluation stage advances when the result register is free.
  assign adv          = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || adv;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_sel_r <= 1'b0;
      thresh_r   <= THRESH_RESET;
      delay_r    <= DELAY_RESET;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_SOFT_SEL:  soft_sel_r <= pwdata[0];
        REG_THRESHOLD: thresh_r   <= pwdata[THRESH_WIDTH-1:0];
        REG_DELAY:     delay_r    <= pwdata[DELAY_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_SOFT_SEL:  prdata = {{(CFG_DATA_WIDTH-1){1'b0}}, soft_sel_r};
      REG_THRESHOLD: prdata = {{(CFG_DATA_WIDTH-THRESH_WIDTH){1'b0}}, thresh_r};
      REG_DELAY:     prdata = {{(CFG_DATA_WIDTH-DELAY_WIDTH){1'b0}}, delay_r};
      default:       prdata = '0;
    endcase
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_brake_r   <= in_bus.brake_released;
      s1_nonzero_r <= in_bus.speed_nonzero;
      s1_soft_r    <= in_bus.soft_limits;
      s1_hard_r    <= in_bus.hard_limits;
      s1_reg_r     <= in_bus.regulating;
      s1_masks_r   <= in_bus.homing_masks;
      s1_src_r     <= in_bus.command_source;
      s1_mode_r    <= in_bus.mode_group;
      s1_cmd_r     <= in_bus.command_value;
      s1_act_r     <= in_bus.actual_position;
      s1_spd_r     <= in_bus.speed_feedback;
    end
  end

  // Direction from the sign of a value.
  function automatic dir_t sign_dir(input logic signed [POS_WIDTH-1:0] v);
    if (v > 0)      return DIR_POS;
    else if (v < 0) return DIR_NEG;
    else            return DIR_NONE;
  endfunction

  // Direction from a target compared with the actual position.
  function automatic dir_t cmp_dir(input logic signed [POS_WIDTH-1:0] t,
                                   input logic signed [POS_WIDTH-1:0] a);
    if (t > a)      return DIR_POS;
    else if (t < a) return DIR_NEG;
    else            return DIR_NONE;
  endfunction

  // Commanded direction from source and mode.
  dir_t cmd_dir;
  always_comb begin
    cmd_dir = DIR_NONE;
    case (s1_src_r)
      SRC_REMOTE: begin
        if (s1_mode_r == MODE_REMOTE_POS) cmd_dir = cmp_dir(s1_cmd_r, s1_act_r);
        else                              cmd_dir = sign_dir(s1_cmd_r);
      end
      SRC_CMBUS: begin
        if (s1_mode_r == MODE_CMBUS_SPD || s1_mode_r == MODE_CMBUS_TORQUE) begin
          cmd_dir = sign_dir(s1_cmd_r);
        end else if (s1_mode_r == MODE_CMBUS_SYNC) begin
          cmd_dir = cmp_dir(s1_cmd_r, s1_act_r);
        end
      end
      default: cmd_dir = DIR_NONE;
    endcase
  end

  // Speed magnitude against the lock threshold.
  logic signed [MAG_WIDTH-1:0] spd_ext;
  logic [MAG_WIDTH-1:0]        spd_mag;
  logic                        at_rest;
  assign spd_ext = MAG_WIDTH'(s1_spd_r);
  assign spd_mag = (s1_spd_r < 0) ? MAG_WIDTH'(-spd_ext) : MAG_WIDTH'(spd_ext);
  assign at_rest = spd_mag <= MAG_WIDTH'(thresh_r);

  // Tick evaluation: next protection state and result flags.
  logic [1:0]           lim;
  logic                 cmd_ok;
  logic [DELAY_WIDTH:0] cnt_inc;
  logic [DELAY_WIDTH:0] cnt_hold;
  logic                 do_stop;
  always_comb begin
    dir_nxt   = dir_r;
    stop_nxt  = stop_r;
    lock_nxt  = lock_r;
    refd_nxt  = refd_r;
    latch_nxt = latch_r;
    warn_nxt  = warn_r;
    count_nxt = count_r;
    load_nxt  = 1'b0;
    seed_nxt  = '0;
    rpos_nxt  = 1'b0;
    rneg_nxt  = 1'b0;
    clr_nxt   = 1'b0;
    do_stop   = 1'b0;
    cmd_ok    = s1_brake_r && s1_nonzero_r;
    lim       = soft_sel_r ? s1_soft_r : s1_hard_r;
    cnt_inc   = {1'b0, count_r} + 1'b1;
    cnt_hold  = {1'b0, delay_r} + 1'b1;

    if (cmd_ok) begin
      // Sticky direction fold.
      if (lim[0])      dir_nxt = dir_r | DIR_POS;
      else if (lim[1]) dir_nxt = dir_r | DIR_NEG;
      else             dir_nxt = DIR_NONE;
      count_nxt = '0;

      if (dir_nxt == DIR_BOTH) begin
        do_stop  = 1'b1;
        warn_nxt = 1'b1;
        rpos_nxt = 1'b1;
        rneg_nxt = 1'b1;
      end else if (dir_nxt == DIR_NONE || cmd_dir != dir_nxt) begin
        if (dir_nxt != DIR_NONE) refd_nxt = cmd_dir;
        stop_nxt  = 1'b0;
        lock_nxt  = 1'b0;
        if (dir_nxt == DIR_NONE) refd_nxt = DIR_NONE;
        else                     refd_nxt = DIR_NONE;
        latch_nxt = DIR_NONE;
        if (warn_r) begin
          warn_nxt = 1'b0;
          clr_nxt  = 1'b1;
        end
      end else begin
        // Command runs into the single active limit.
        refd_nxt  = cmd_dir;
        latch_nxt = dir_nxt;
        if (dir_nxt == DIR_POS && s1_reg_r && !s1_masks_r[0]) begin
          warn_nxt = 1'b1;
          rpos_nxt = 1'b1;
          do_stop  = 1'b1;
        end else if (dir_nxt == DIR_NEG && s1_reg_r && !s1_masks_r[1]) begin
          warn_nxt = 1'b1;
          rneg_nxt = 1'b1;
          do_stop  = 1'b1;
        end
      end

      // Zero-speed stop and position lock.
      if (do_stop && !lock_r) begin
        if (!stop_r) begin
          stop_nxt = 1'b1;
          load_nxt = 1'b1;
          seed_nxt = s1_spd_r;
        end
        if (at_rest) begin
          stop_nxt = 1'b0;
          lock_nxt = 1'b1;
        end
      end
    end else begin
      // Drive disabled: release and count toward the continuous clear.
      warn_nxt  = 1'b0;
      stop_nxt  = 1'b0;
      lock_nxt  = 1'b0;
      refd_nxt  = DIR_NONE;
      latch_nxt = DIR_NONE;
      count_nxt = (cnt_inc > COUNT_MAX) ? COUNT_MAX[DELAY_WIDTH-1:0]
                                        : cnt_inc[DELAY_WIDTH-1:0];
      if (cnt_inc > {1'b0, delay_r}) begin
        count_nxt = (cnt_hold > COUNT_MAX) ? COUNT_MAX[DELAY_WIDTH-1:0]
                                           : cnt_hold[DELAY_WIDTH-1:0];
        clr_nxt   = 1'b1;
      end
    end
  end

  // Protection state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= DIR_NONE;
      stop_r      <= 1'b0;
      lock_r      <= 1'b0;
      refd_r      <= DIR_NONE;
      latch_r     <= DIR_NONE;
      warn_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        dir_r   <= dir_nxt;
        stop_r  <= stop_nxt;
        lock_r  <= lock_nxt;
        refd_r  <= refd_nxt;
        latch_r <= latch_nxt;
        warn_r  <= warn_nxt;
        count_r <= count_nxt;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      load_r <= load_nxt;
      seed_r <= seed_nxt;
      rpos_r <= rpos_nxt;
      rneg_r <= rneg_nxt;
      clr_r  <= clr_nxt;
    end
  end

  // The state registers double as the result's state fields.
  assign out_bus.valid           = out_valid_r;
  assign out_bus.overtravel_dir  = dir_r;
  assign out_bus.ref_dir         = refd_r;
  assign out_bus.stopping        = stop_r;
  assign out_bus.position_locked = lock_r;
  assign out_bus.load_stop_speed = load_r;
  assign out_bus.stop_speed      = seed_r;
  assign out_bus.raise_pos_warn  = rpos_r;
  assign out_bus.raise_neg_warn  = rneg_r;
  assign out_bus.clear_warns     = clr_r;
  assign out_bus.latched_dir     = latch_r;

  // A stop and a lock are never held together.
  `SOP_ASSERT_IMPL(a_stop_lock_excl, stop_r, !lock_r, "stop and lock active together")
  // A running disable count means everything has been released.
  `SOP_ASSERT_IMPL(a_count_released, count_r != '0, !warn_r && !stop_r && !lock_r,
                   "disable count running with protection state active")
  // A seeded stop shows up as a stop or an immediate lock.
  `SOP_ASSERT_IMPL(a_load_stop, out_valid_r && load_r, stop_r || lock_r,
                   "stop seed without stop or lock")
  // State moves only when a tick is evaluated.
  `SOP_ASSERT_NEXT(a_state_hold, !adv, $stable(dir_r) && $stable(warn_r) && $stable(count_r),
                   "protection state changed without an evaluated tick")

endmodule

[tb/sv/servo_overtravel_protect_core_tb.sv]
// Self-checking testbench of the servo overtravel protection core.
`timescale 1ns / 1ps

module servo_overtravel_protect_core_tb
  import sop_pkg::*;
();

  // Command sources and mode groups that the package leaves unnamed.
  localparam logic [1:0] SRC_INTERNAL       = 2'd0;
  localparam logic [1:0] SRC_OTHER          = 2'd3;
  localparam logic [2:0] MODE_REMOTE_VEL    = 3'd0;
  localparam logic [2:0] MODE_REMOTE_TORQUE = 3'd2;
  localparam logic [2:0] MODE_REMOTE_OTHER  = 3'd3;
  localparam logic [2:0] MODE_CMBUS_POS     = 3'd0;
  localparam logic [2:0] MODE_CMBUS_OTHER   = 3'd4;

  localparam int HANG_LIMIT  = 2000;
  localparam int PRINT_LIMIT = 50;

  // One control tick as presented on the request channel.
  typedef struct packed {
    logic              brake;
    logic              speed_nz;
    logic [1:0]        soft_lim;
    logic [1:0]        hard;
    logic              regulating;
    logic [1:0]        masks;
    logic [1:0]        src;
    logic [2:0]        mode;
    logic signed [31:0] cmd;
    logic signed [31:0] act;
    logic signed [15:0] spd;
  } tick_req_t;

  // Protection outputs of one tick.
  typedef struct packed {
    dir_t               ot;
    dir_t               rdir;
    logic               stopping;
    logic               locked;
    logic               load;
    logic signed [15:0] seed;
    logic               rpos;
    logic               rneg;
    logic               clr;
    dir_t               latched;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n;

  sop_in_if  #(.POS_WIDTH(32), .SPEED_WIDTH(16)) in_bus ();
  sop_out_if #(.SPEED_WIDTH(16))                 out_bus ();

  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [CFG_ADDR_WIDTH-1:0] paddr;
  logic [CFG_DATA_WIDTH-1:0] pwdata;
  logic [CFG_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  servo_overtravel_protect_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Predictor copy of the configuration.
  logic        use_soft;
  logic [14:0] lock_thresh;
  logic [10:0] clear_delay;

  // Predictor copy of the protection state, at its reset values.
  dir_t ot_dir        = DIR_NONE;
  logic stop_on       = 1'b0;
  logic lock_on       = 1'b0;
  dir_t cmd_dir       = DIR_NONE;
  dir_t latch_dir     = DIR_NONE;
  logic warn_on       = 1'b0;
  int   disable_ticks = 0;

  tick_req_t    pending[$];
  tick_result_t expected[$];
  tick_req_t    held_req;

  int  queued_total = 0;
  int  results_seen = 0;
  int  errors = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // Direction the command asks for, from source, mode and values.
  function automatic dir_t commanded_dir(tick_req_t r);
    dir_t by_sign;
    dir_t by_target;
    by_sign = ($signed(r.cmd) > 0) ? DIR_POS : (($signed(r.cmd) < 0) ? DIR_NEG : DIR_NONE);
    by_target = ($signed(r.cmd) > $signed(r.act)) ? DIR_POS :
                (($signed(r.cmd) < $signed(r.act)) ? DIR_NEG : DIR_NONE);
    if (r.src == SRC_REMOTE) begin
      return (r.mode == MODE_REMOTE_POS) ? by_target : by_sign;
    end
    if (r.src == SRC_CMBUS) begin
      if (r.mode == MODE_CMBUS_SPD || r.mode == MODE_CMBUS_TORQUE) return by_sign;
      if (r.mode == MODE_CMBUS_SYNC) return by_target;
    end
    return DIR_NONE;
  endfunction

  function automatic void drop_stop();
    stop_on   = 1'b0;
    lock_on   = 1'b0;
    cmd_dir   = DIR_NONE;
    latch_dir = DIR_NONE;
  endfunction

  // Start the zero-speed stop once, then lock when the speed is low enough.
  function automatic void engage_stop(input logic signed [15:0] spd, inout tick_result_t res);
    int mag;
    if (lock_on) return;
    if (!stop_on) begin
      stop_on  = 1'b1;
      res.load = 1'b1;
      res.seed = spd;
    end
    mag = ($signed(spd) < 0) ? -int'($signed(spd)) : int'($signed(spd));
    if (mag <= int'(lock_thresh)) begin
      stop_on = 1'b0;
      lock_on = 1'b1;
    end
  endfunction

  // Advance the protection state by one accepted tick and return its outputs.
  function automatic tick_result_t advance_protection(tick_req_t r);
    tick_result_t res;
    logic [1:0]   lim;
    int           nxt;
    res = '0;
    if (r.brake && r.speed_nz) begin
      lim = use_soft ? r.soft_lim : r.hard;
      if (lim[0]) ot_dir = ot_dir | DIR_POS;
      else if (lim[1]) ot_dir = ot_dir | DIR_NEG;
      else ot_dir = DIR_NONE;

      if (ot_dir == DIR_BOTH) begin
        engage_stop(r.spd, res);
        warn_on  = 1'b1;
        res.rpos = 1'b1;
        res.rneg = 1'b1;
      end else if (ot_dir == DIR_NONE) begin
        drop_stop();
        if (warn_on) begin
          warn_on = 1'b0;
          res.clr = 1'b1;
        end
      end else begin
        cmd_dir = commanded_dir(r);
        if (cmd_dir == ot_dir) begin
          if (ot_dir == DIR_POS) begin
            if (r.regulating && !r.masks[0]) begin
              warn_on  = 1'b1;
              res.rpos = 1'b1;
              engage_stop(r.spd, res);
            end
          end else if (r.regulating && !r.masks[1]) begin
            warn_on  = 1'b1;
            res.rneg = 1'b1;
            engage_stop(r.spd, res);
          end
          latch_dir = ot_dir;
        end else begin
          drop_stop();
          if (warn_on) begin
            warn_on = 1'b0;
            res.clr = 1'b1;
          end
        end
      end
      disable_ticks = 0;
    end else begin
      // Drive disabled: count ticks and clear warnings once past the delay.
      nxt = disable_ticks + 1;
      warn_on = 1'b0;
      drop_stop();
      disable_ticks = (nxt > 2047) ? 2047 : nxt;
      if (nxt > int'(clear_delay)) begin
        disable_ticks = (int'(clear_delay) + 1 > 2047) ? 2047 : int'(clear_delay) + 1;
        res.clr = 1'b1;
      end
    end
    res.ot       = ot_dir;
    res.rdir     = cmd_dir;
    res.stopping = stop_on;
    res.locked   = lock_on;
    res.latched  = latch_dir;
    return res;
  endfunction

  function automatic void enqueue(tick_req_t r);
    pending.push_back(r);
    queued_total++;
  endfunction

  function automatic void add_req(logic br, logic nz, logic [1:0] soft_lim, logic [1:0] hard,
                                  logic regl, logic [1:0] masks, logic [1:0] src,
                                  logic [2:0] mode, logic signed [31:0] cmd,
                                  logic signed [31:0] act, logic signed [15:0] spd);
    tick_req_t r;
    r.brake      = br;
    r.speed_nz   = nz;
    r.soft_lim   = soft_lim;
    r.hard       = hard;
    r.regulating = regl;
    r.masks      = masks;
    r.src        = src;
    r.mode       = mode;
    r.cmd        = cmd;
    r.act        = act;
    r.spd        = spd;
    enqueue(r);
  endfunction

  function automatic tick_req_t random_req();
    tick_req_t r;
    r.brake      = 1'($urandom_range(0, 1));
    r.speed_nz   = 1'($urandom_range(0, 1));
    r.soft_lim   = 2'($urandom_range(0, 3));
    r.hard       = 2'($urandom_range(0, 3));
    r.regulating = 1'($urandom_range(0, 1));
    r.masks      = 2'($urandom_range(0, 3));
    r.src        = 2'($urandom_range(0, 3));
    r.mode       = 3'($urandom_range(0, 4));
    r.cmd        = $urandom;
    r.act        = ($urandom_range(0, 7) == 0) ? r.cmd : $urandom;
    r.spd        = 16'($urandom);
    return r;
  endfunction

  // Pick a source, mode and values that command direction d.
  function automatic void aim_command(inout tick_req_t r, input dir_t d);
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic [30:0]        mag;
    int                 m;
    a   = $urandom;
    b   = $urandom;
    hi  = (a > b) ? a : b;
    lo  = (a > b) ? b : a;
    mag = 31'($urandom);
    if (mag == '0) mag = 31'd1;
    case ($urandom_range(0, 3))
      0: begin
        m = $urandom_range(0, 3);
        if (m >= 1) m++;
        r.src  = SRC_REMOTE;
        r.mode = m[2:0];
      end
      1: begin
        r.src  = SRC_REMOTE;
        r.mode = MODE_REMOTE_POS;
      end
      2: begin
        r.src  = SRC_CMBUS;
        r.mode = $urandom_range(0, 1) ? MODE_CMBUS_SPD : MODE_CMBUS_TORQUE;
      end
      default: begin
        r.src  = SRC_CMBUS;
        r.mode = MODE_CMBUS_SYNC;
      end
    endcase
    if ((r.src == SRC_REMOTE && r.mode == MODE_REMOTE_POS) ||
        (r.src == SRC_CMBUS && r.mode == MODE_CMBUS_SYNC)) begin
      r.cmd = (d == DIR_POS) ? hi : lo;
      r.act = (d == DIR_POS) ? lo : hi;
    end else begin
      r.cmd = (d == DIR_POS) ? {1'b0, mag} : {1'b1, mag};
    end
  endfunction

  // Directed ticks under the reset configuration (hard limits, threshold 24).
  task automatic queue_directed();
    add_req(0, 0, 0, 0, 0, 0, SRC_INTERNAL, MODE_REMOTE_VEL, 0, 0, 0);
    add_req(1, 0, 3, 3, 1, 3, SRC_OTHER, MODE_CMBUS_OTHER, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    add_req(1, 1, 3, 0, 1, 0, SRC_REMOTE, MODE_REMOTE_VEL, 0, 0, 0);
    // Run into the positive limit, slow down, then lock.
    add_req(1, 1, 0, DIR_POS, 1, 0, SRC_REMOTE, MODE_REMOTE_VEL, 32'h7FFFFFFF, 0, 16'h8000);
    add_req(1, 1, 0, DIR_POS, 1, 0, SRC_REMOTE, MODE_REMOTE_VEL, 32'h7FFFFFFF, 0, 100);
    add_req(1, 1, 0, DIR_POS, 1, 0, SRC_REMOTE, MODE_REMOTE_VEL, 1, 0, -24);
    add_req(1, 1, 0, DIR_POS, 1, 0, SRC_REMOTE, MODE_REMOTE_VEL, 1, 0, 0);
    add_req(1, 1, 0, 0, 1, 0, SRC_REMOTE, MODE_REMOTE_VEL, 1, 0, 0);
    // Negative limit with target below the actual position, then masked and not regulating.
    add_req(1, 1, 0, DIR_NEG, 1, 0, SRC_CMBUS, MODE_CMBUS_SYNC,
            32'h80000000, 32'h7FFFFFFF, 16'h7FFF);
    add_req(1, 1, 0, DIR_NEG, 1, 2'b10, SRC_CMBUS, MODE_CMBUS_TORQUE, -5, 0, 3000);
    add_req(1, 1, 0, DIR_NEG, 0, 0, SRC_CMBUS, MODE_CMBUS_SPD, -1, 0, -3000);
    // Both limits seen: stop regardless of command, both warnings raised.
    add_req(1, 1, 0, DIR_POS, 0, 3, SRC_INTERNAL, MODE_REMOTE_VEL, 0, 0, 24);
    add_req(1, 1, 0, DIR_BOTH, 0, 3, SRC_OTHER, MODE_CMBUS_OTHER, 0, 0, -32768);
    add_req(1, 1, 0, 0, 1, 0, SRC_INTERNAL, MODE_REMOTE_VEL, 0, 0, 0);
    // Commands that give no direction, the wrong one or the limit's own, and a disabled tick.
    add_req(1, 1, 0, DIR_POS, 1, 0, SRC_CMBUS, MODE_CMBUS_POS, 5, 0, 500);
    add_req(1, 1, 0, DIR_POS, 1, 1, SRC_REMOTE, MODE_REMOTE_POS, 100, 100, 500);
    add_req(1, 1, 0, DIR_POS, 1, 2'b01, SRC_REMOTE, MODE_REMOTE_POS, 101, 100, 500);
    add_req(1, 1, 0, DIR_POS, 1, 0, SRC_REMOTE, MODE_REMOTE_OTHER, 1, 0, -25);
    add_req(1, 1, 0, DIR_POS, 1, 0, SRC_REMOTE, MODE_REMOTE_TORQUE, -1, 0, -25);
    add_req(1, 1, 0, DIR_POS, 1, 0, SRC_CMBUS, MODE_CMBUS_OTHER, 9, 0, 7);
    add_req(0, 1, 0, DIR_POS, 1, 0, SRC_REMOTE, MODE_REMOTE_VEL, 9, 0, 7);
    add_req(1, 1, 0, DIR_NEG, 1, 0, SRC_REMOTE, MODE_CMBUS_OTHER, -7, 0, 7);
  endtask

  // Random episodes: approaches into one limit, both limits, disabled stretches and noise.
  task automatic queue_random(int n);
    tick_req_t          r;
    int                 left;
    int                 span;
    int                 kind;
    int                 k;
    dir_t               aim;
    logic [1:0]         lim;
    logic signed [15:0] spd;
    left = n;
    while (left > 0) begin
      span = $urandom_range(2, 14);
      kind = $urandom_range(0, 9);
      aim  = $urandom_range(0, 1) ? DIR_POS : DIR_NEG;
      spd  = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 60)) - 16'sd30 : 16'($urandom);
      for (k = 0; k < span && left > 0; k++) begin
        r = random_req();
        if (kind == 0) begin
          r.speed_nz = r.brake ? 1'b0 : r.speed_nz;
        end else if (kind != 1) begin
          r.brake    = 1'b1;
          r.speed_nz = ($urandom_range(0, 19) != 0);
          if (kind <= 3) lim = (k == 0) ? ($urandom_range(0, 1) ? DIR_POS : DIR_BOTH) : DIR_NEG;
          else lim = aim;
          if ($urandom_range(0, 9) == 0) lim = DIR_NONE;
          if (use_soft) r.soft_lim = lim;
          else r.hard = lim;
          r.regulating = ($urandom_range(0, 7) != 0);
          r.masks      = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(0, 3)) : 2'b00;
          if ($urandom_range(0, 6) != 0) begin
            aim_command(r, (kind <= 3) ? dir_t'($urandom_range(1, 2)) : aim);
          end
          r.spd = spd;
          spd   = 16'(spd / 3);
        end
        enqueue(r);
        left--;
      end
    end
  endtask

  // Two-phase register write; the predictor takes the value at the commit edge.
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SOFT_SEL:  use_soft    = val[0];
      REG_THRESHOLD: lock_thresh = val[14:0];
      REG_DELAY:     clear_delay = val[10:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (results_seen < queued_total) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected.push_back(advance_protection(held_req));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (!calm && pending.size() != 0 && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 16);
          in_bus.valid <= 1'b0;
        end else if (pending.size() != 0) begin
          held_req = pending.pop_front();
          in_bus.brake_released  <= held_req.brake;
          in_bus.speed_nonzero   <= held_req.speed_nz;
          in_bus.soft_limits     <= held_req.soft_lim;
          in_bus.hard_limits     <= held_req.hard;
          in_bus.regulating      <= held_req.regulating;
          in_bus.homing_masks    <= held_req.masks;
          in_bus.command_source  <= held_req.src;
          in_bus.mode_group      <= held_req.mode;
          in_bus.command_value   <= held_req.cmd;
          in_bus.actual_position <= held_req.act;
          in_bus.speed_feedback  <= held_req.spd;
          in_bus.valid           <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        got.ot       = out_bus.overtravel_dir;
        got.rdir     = out_bus.ref_dir;
        got.stopping = out_bus.stopping;
        got.locked   = out_bus.position_locked;
        got.load     = out_bus.load_stop_speed;
        got.seed     = out_bus.stop_speed;
        got.rpos     = out_bus.raise_pos_warn;
        got.rneg     = out_bus.raise_neg_warn;
        got.clr      = out_bus.clear_warns;
        got.latched  = out_bus.latched_dir;
        if (expected.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected.pop_front();
          compare_field("overtravel_dir", 32'(got.ot), 32'(want.ot));
          compare_field("ref_dir", 32'(got.rdir), 32'(want.rdir));
          compare_field("stopping", 32'(got.stopping), 32'(want.stopping));
          compare_field("position_locked", 32'(got.locked), 32'(want.locked));
          compare_field("load_stop_speed", 32'(got.load), 32'(want.load));
          compare_field("stop_speed", 32'(got.seed), 32'(want.seed));
          compare_field("raise_pos_warn", 32'(got.rpos), 32'(want.rpos));
          compare_field("raise_neg_warn", 32'(got.rneg), 32'(want.rneg));
          compare_field("clear_warns", 32'(got.clr), 32'(want.clr));
          compare_field("latched_dir", 32'(got.latched), 32'(want.latched));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Hang detection: too long without any handshake or register access.
  always @(posedge clk) begin
    if (!rst_n || psel || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n       <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    use_soft    = 1'b0;
    lock_thresh = THRESH_RESET;
    clear_delay = DELAY_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    queue_directed();
    wait_idle();

    // Soft limits, zero threshold, immediate clearing.
    write_reg(REG_SOFT_SEL, 32'd1);
    write_reg(REG_THRESHOLD, 32'd0);
    write_reg(REG_DELAY, 32'd0);
    queue_random(120);
    wait_idle();

    // Hard limits, largest threshold and delay.
    write_reg(REG_SOFT_SEL, 32'd0);
    write_reg(REG_THRESHOLD, 32'd32767);
    write_reg(REG_DELAY, 32'd2047);
    queue_random(100);
    wait_idle();

    write_reg(REG_SOFT_SEL, 32'd1);
    write_reg(REG_THRESHOLD, $urandom_range(100, 3000));
    write_reg(REG_DELAY, $urandom_range(1, 12));
    queue_random(150);
    wait_idle();

    // Final stretch at full rate on both sides.
    write_reg(REG_SOFT_SEL, 32'd0);
    write_reg(REG_THRESHOLD, 32'd500);
    write_reg(REG_DELAY, 32'd4);
    calm = 1'b1;
    queue_random(180);
    wait_idle();
    repeat (8) @(posedge clk);

    if (expected.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", expected.size()));
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
